// ===== hw/rtl/fsnc_pkg.sv =====
// Shared types and constants for the FAT short name converter.
`timescale 1ns / 1ps

package fsnc_pkg;

    localparam int NameLen  = 12;
    localparam int ShortLen = 11;
    localparam int BaseLen  = 8;
    localparam int ExtLen   = ShortLen - BaseLen;
    localparam int DotW     = $clog2(NameLen);

    localparam logic [7:0] CharNul   = 8'h00;
    localparam logic [7:0] CharSpace = 8'h20;
    localparam logic [7:0] CharDot   = 8'h2e;
    localparam logic [7:0] LowerA    = 8'h61;
    localparam logic [7:0] LowerZ    = 8'h7a;
    localparam logic [7:0] CaseDelta = 8'h20;

    typedef logic [NameLen-1:0][7:0] name_arr_t;

    // Input transaction payload.
    typedef struct packed {
        logic [7:0] name_char_0;
        logic [7:0] name_char_1;
        logic [7:0] name_char_2;
        logic [7:0] name_char_3;
        logic [7:0] name_char_4;
        logic [7:0] name_char_5;
        logic [7:0] name_char_6;
        logic [7:0] name_char_7;
        logic [7:0] name_char_8;
        logic [7:0] name_char_9;
        logic [7:0] name_char_10;
        logic [7:0] name_char_11;
    } name_t;

    // Result transaction payload.
    typedef struct packed {
        logic [7:0] short_char_0;
        logic [7:0] short_char_1;
        logic [7:0] short_char_2;
        logic [7:0] short_char_3;
        logic [7:0] short_char_4;
        logic [7:0] short_char_5;
        logic [7:0] short_char_6;
        logic [7:0] short_char_7;
        logic [7:0] short_char_8;
        logic [7:0] short_char_9;
        logic [7:0] short_char_10;
        logic       invalid;
    } short_t;

    // Payload after the dot search stage.
    typedef struct packed {
        name_arr_t         chars;
        logic              found;
        logic [DotW-1:0]   dot;
    } loc_t;

    // Uppercase conversion of one ASCII byte.
    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= LowerA && c <= LowerZ) begin
            r = c - CaseDelta;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/fat_short_name_converter_unit.sv =====
// Top level of the FAT 8.3 short name converter.
`timescale 1ns / 1ps
//
// Converts a 12-byte file name into an 11-byte FAT short name.
// Input channel s_valid/s_ready/s_data carries one name per transaction;
// result channel m_valid/m_ready/m_data carries one short name per name.
// Bytes after the first NUL count as NUL; lowercase letters are uppercased.
// A name that starts with a dot or NUL, or has no dot in positions one to
// eight, gives all-zero bytes with invalid set.
// The pipeline has three register stages: masking and case conversion,
// dot search, and assembly into the output register. An accepted name
// passes through the prep, locate and output registers in turn before
// m_valid rises. Throughput is one transaction per cycle while m_ready
// stays high.
// Each stage holds its data while the stage after it is full and not
// draining, so a stall on m_ready backs up through the stages and then
// drops s_ready; nothing is lost or repeated. The pipeline holds up to
// three transactions.
// Synchronous reset on aresetn low empties all stages.
//
module fat_short_name_converter_unit (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  fsnc_pkg::name_t   s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output fsnc_pkg::short_t  m_data
);

    fsnc_pkg::name_arr_t prep_data;
    logic                prep_valid;
    logic                prep_ready;
    fsnc_pkg::loc_t      loc_data;
    logic                loc_valid;
    logic                loc_ready;

    // Stage one.
    fsnc_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_data  (prep_data)
    );

    // Stage two.
    fsnc_locate u_locate (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (prep_valid),
        .in_ready  (prep_ready),
        .in_data   (prep_data),
        .out_valid (loc_valid),
        .out_ready (loc_ready),
        .out_data  (loc_data)
    );

    // Stage three.
    fsnc_assemble u_assemble (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (loc_valid),
        .in_ready  (loc_ready),
        .in_data   (loc_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef SYNTHESIS
    // Reset empties the pipeline.
    a_reset_empty : assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

    // A rejected name carries zero bytes in positions zero and eight.
    a_invalid_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.invalid) |->
        (m_data.short_char_0 == 8'h00 && m_data.short_char_8 == 8'h00))
        else $error("rejected name with nonzero bytes");

    // An accepted name starts with a real character and has no NUL in the extension.
    a_valid_bytes : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.invalid) |->
        (m_data.short_char_0 != fsnc_pkg::CharNul && m_data.short_char_0 != fsnc_pkg::CharDot
         && m_data.short_char_8 != fsnc_pkg::CharNul
         && m_data.short_char_9 != fsnc_pkg::CharNul
         && m_data.short_char_10 != fsnc_pkg::CharNul))
        else $error("accepted name with bad bytes");
`endif

endmodule

// ===== hw/rtl/fsnc_prep.sv =====
// Stage one: NUL masking and case conversion of the input name.
`timescale 1ns / 1ps

module fsnc_prep (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsnc_pkg::name_t     in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fsnc_pkg::name_arr_t out_data
);

    fsnc_pkg::name_arr_t raw;
    fsnc_pkg::name_arr_t data_next;
    fsnc_pkg::name_arr_t data_reg;
    logic                valid_reg;
    logic                seen_nul;

    // Unpack the transaction into a byte array.
    assign raw[0]  = in_data.name_char_0;
    assign raw[1]  = in_data.name_char_1;
    assign raw[2]  = in_data.name_char_2;
    assign raw[3]  = in_data.name_char_3;
    assign raw[4]  = in_data.name_char_4;
    assign raw[5]  = in_data.name_char_5;
    assign raw[6]  = in_data.name_char_6;
    assign raw[7]  = in_data.name_char_7;
    assign raw[8]  = in_data.name_char_8;
    assign raw[9]  = in_data.name_char_9;
    assign raw[10] = in_data.name_char_10;
    assign raw[11] = in_data.name_char_11;

    // Every byte from the first NUL on becomes NUL; the rest are uppercased.
    always_comb begin
        seen_nul = 1'b0;
        for (int i = 0; i < fsnc_pkg::NameLen; i++) begin
            if (raw[i] == fsnc_pkg::CharNul) begin
                seen_nul = 1'b1;
            end
            data_next[i] = seen_nul ? fsnc_pkg::CharNul : fsnc_pkg::upcase(raw[i]);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/fsnc_locate.sv =====
// Stage two: search for the first dot and check the name.
`timescale 1ns / 1ps

module fsnc_locate (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fsnc_pkg::name_arr_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fsnc_pkg::loc_t      out_data
);

    fsnc_pkg::loc_t data_next;
    fsnc_pkg::loc_t data_reg;
    logic           valid_reg;
    logic           lead_ok;
    logic           any_dot;

    // The first dot at positions one through eight wins; scan from the top down.
    always_comb begin
        any_dot = 1'b0;
        data_next.dot = '0;
        for (int i = fsnc_pkg::BaseLen; i >= 1; i--) begin
            if (in_data[i] == fsnc_pkg::CharDot) begin
                any_dot = 1'b1;
                data_next.dot = fsnc_pkg::DotW'(i);
            end
        end
        lead_ok = (in_data[0] != fsnc_pkg::CharDot) && (in_data[0] != fsnc_pkg::CharNul);
        data_next.found = lead_ok && any_dot;
        data_next.chars = in_data;
    end

    assign in_ready = !valid_reg || out_ready;

    // Stage register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hw/rtl/fsnc_assemble.sv =====
// Stage three: build the padded base and extension into the output register.
`timescale 1ns / 1ps

module fsnc_assemble (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  fsnc_pkg::loc_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output fsnc_pkg::short_t   out_data
);

    logic [fsnc_pkg::ShortLen-1:0][7:0] sn;
    fsnc_pkg::short_t                   data_next;
    fsnc_pkg::short_t                   data_reg;
    logic                               valid_reg;
    logic [fsnc_pkg::DotW-1:0]          src;
    logic [7:0]                         ext_c;

    // Base bytes before the dot are kept, the rest padded with spaces.
    // Extension bytes follow the dot and turn into spaces at the first NUL; an invalid name gives all zero bytes.
    always_comb begin
        src   = '0;
        ext_c = '0;
        for (int k = 0; k < fsnc_pkg::BaseLen; k++) begin
            sn[k] = (fsnc_pkg::DotW'(k) < in_data.dot) ? in_data.chars[k]
                                                        : fsnc_pkg::CharSpace;
        end
        for (int j = 0; j < fsnc_pkg::ExtLen; j++) begin
            src   = in_data.dot + fsnc_pkg::DotW'(j + 1);
            ext_c = in_data.chars[src];
            sn[fsnc_pkg::BaseLen + j] = (ext_c == fsnc_pkg::CharNul) ? fsnc_pkg::CharSpace
                                                                     : ext_c;
        end
        if (!in_data.found) begin
            sn = '0;
        end
    end

    // Pack the result transaction.
    assign data_next.short_char_0  = sn[0];
    assign data_next.short_char_1  = sn[1];
    assign data_next.short_char_2  = sn[2];
    assign data_next.short_char_3  = sn[3];
    assign data_next.short_char_4  = sn[4];
    assign data_next.short_char_5  = sn[5];
    assign data_next.short_char_6  = sn[6];
    assign data_next.short_char_7  = sn[7];
    assign data_next.short_char_8  = sn[8];
    assign data_next.short_char_9  = sn[9];
    assign data_next.short_char_10 = sn[10];
    assign data_next.invalid       = !in_data.found;

    assign in_ready = !valid_reg || out_ready;

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
